// File: sv/fssa_pkg.sv
// ---------------------------------------------------------------------------
// fssa_pkg
// Shared types and codes for the film sample splat accumulator.
// ---------------------------------------------------------------------------
package fssa_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] REG_X_START = 3'd0;
	localparam logic [2:0] REG_Y_START = 3'd1;
	localparam logic [2:0] REG_X_COUNT = 3'd2;
	localparam logic [2:0] REG_Y_COUNT = 3'd3;
	localparam logic [2:0] REG_X_RAD   = 3'd4;
	localparam logic [2:0] REG_Y_RAD   = 3'd5;
	localparam logic [2:0] REG_X_INV   = 3'd6;
	localparam logic [2:0] REG_Y_INV   = 3'd7;

	localparam int SUM_W = 48;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// one pixel's five sums
	typedef struct packed {
		logic signed [SUM_W-1:0] red;
		logic signed [SUM_W-1:0] green;
		logic signed [SUM_W-1:0] blue;
		logic signed [SUM_W-1:0] alpha;
		logic signed [SUM_W-1:0] weight;
	} pix_t;

	// saturating 48-bit add
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		return s[SUM_W-1:0];
	endfunction

endpackage

// File: sv/film_sample_splat_accumulator.sv
// Film sample splat accumulator. An add beat walks the clipped footprint of
// the sample one pixel at a time through a shared distance multiplier and one
// weight multiplier per colour and alpha channel, with a read-modify-write of
// the pixel store, before its result beat; a footprint that misses the film
// sets status. Table loads and pixel reads also end in a result beat. The next
// input beat can be taken in the cycle after the result beat is accepted. After
// reset a clearing pass zeroes the store, one pixel a cycle, and no input
// beat is taken meanwhile.
// ---------------------------------------------------------------------------
// film_sample_splat_accumulator
// Splats image samples through a tabulated filter into a pixel store.
// ---------------------------------------------------------------------------
module film_sample_splat_accumulator import fssa_pkg::*; #(
	parameter int TABLE_SIDE      = 16,
	parameter int MAX_FILM_WIDTH  = 64,
	parameter int MAX_FILM_HEIGHT = 64,
	parameter int MAX_RADIUS      = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [23:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              operation,
	input  logic [19:0]             sample_x,
	input  logic [19:0]             sample_y,
	input  logic [23:0]             radiance_red,
	input  logic [23:0]             radiance_green,
	input  logic [23:0]             radiance_blue,
	input  logic [16:0]             sample_alpha,
	input  logic [7:0]              table_index,
	input  logic signed [15:0]      table_weight,
	input  logic [5:0]              pixel_column,
	input  logic [5:0]              pixel_row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    status,
	output logic signed [SUM_W-1:0] red_sum,
	output logic signed [SUM_W-1:0] green_sum,
	output logic signed [SUM_W-1:0] blue_sum,
	output logic signed [SUM_W-1:0] alpha_sum,
	output logic signed [SUM_W-1:0] weight_total
);

	localparam int NTAB  = TABLE_SIDE * TABLE_SIDE;
	localparam int TB    = $clog2(TABLE_SIDE);
	localparam int TAB_W = $clog2(NTAB);
	localparam int XB    = $clog2(MAX_FILM_WIDTH);
	localparam int YB    = $clog2(MAX_FILM_HEIGHT);
	localparam int NPIX  = MAX_FILM_WIDTH * MAX_FILM_HEIGHT;
	localparam int PB    = XB + YB;
	localparam int RMAX  = MAX_RADIUS * 256;
	// signed coordinate width: position Q12.8 plus radius plus sign
	localparam int CW    = 23;
	localparam int PIXW  = CW - 8;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SETUP = 4'd2;
	localparam logic [3:0] ST_CLIP  = 4'd3;
	localparam logic [3:0] ST_ROW   = 4'd4;
	localparam logic [3:0] ST_TX    = 4'd5;
	localparam logic [3:0] ST_RD    = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_WR    = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_PRD   = 4'd10;
	localparam logic [3:0] ST_PRD2  = 4'd11;
	localparam logic [3:0] ST_TAB   = 4'd12;

	logic [3:0] state_q;

	// configuration registers
	logic [11:0] x_start_q, y_start_q;
	logic [6:0]  x_count_q, y_count_q;
	logic [10:0] x_rad_q, y_rad_q;
	logic [23:0] x_inv_q, y_inv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q <= '0;
			y_start_q <= '0;
			x_count_q <= 7'd64;
			y_count_q <= 7'd64;
			x_rad_q   <= 11'd512;
			y_rad_q   <= 11'd512;
			x_inv_q   <= 24'd131072;
			y_inv_q   <= 24'd131072;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_START: x_start_q <= cfg_data[11:0];
				REG_Y_START: y_start_q <= cfg_data[11:0];
				REG_X_COUNT: x_count_q <= cfg_data[6:0];
				REG_Y_COUNT: y_count_q <= cfg_data[6:0];
				REG_X_RAD:   x_rad_q   <= cfg_data[10:0];
				REG_Y_RAD:   y_rad_q   <= cfg_data[10:0];
				REG_X_INV:   x_inv_q   <= cfg_data;
				REG_Y_INV:   y_inv_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective window counts and radii
	logic [PIXW-1:0] xc_eff, yc_eff;
	logic [10:0]     rx_eff, ry_eff;
	always_comb begin
		xc_eff = (x_count_q == '0) ? PIXW'(1) : PIXW'(x_count_q);
		if (xc_eff > PIXW'(MAX_FILM_WIDTH)) xc_eff = PIXW'(MAX_FILM_WIDTH);
		yc_eff = (y_count_q == '0) ? PIXW'(1) : PIXW'(y_count_q);
		if (yc_eff > PIXW'(MAX_FILM_HEIGHT)) yc_eff = PIXW'(MAX_FILM_HEIGHT);
		rx_eff = (32'(x_rad_q) > RMAX) ? 11'(RMAX) : x_rad_q;
		ry_eff = (32'(y_rad_q) > RMAX) ? 11'(RMAX) : y_rad_q;
	end

	// filter table, written by load beats
	logic signed [15:0] wtab [NTAB];
	logic [TAB_W-1:0]   tab_addr;
	logic signed [15:0] tab_q;

	// sample registers
	logic signed [CW-1:0] cx_q, cy_q;
	logic [23:0] rr_q, rg_q, rb_q;
	logic [16:0] al_q;
	logic [5:0]  col_q, row_q;
	logic [7:0]  tidx_q;
	logic signed [15:0] twt_q;

	// footprint bounds in pixels (signed)
	logic signed [PIXW-1:0] x0_q, x1_q, y0_q, y1_q, x_q, y_q;
	logic [TB-1:0] ty_q, tx_q;
	logic [PB-1:0] paddr_q;

	// shared distance unit: |pix*256 - c| * inv * TABLE_SIDE >> 24
	logic                 dist_y;
	logic signed [CW-1:0] d_pix, d_c;
	logic [23:0]          d_inv;
	logic signed [CW:0]   d_diff;
	logic [CW-1:0]        d_abs;
	logic [CW+24-1:0]     d_prod;
	logic [CW+24+TB-1:0]  d_scaled;
	logic [TB-1:0]        d_pos;
	always_comb begin
		d_pix    = CW'(dist_y ? y_q : x_q);
		d_c      = dist_y ? cy_q : cx_q;
		d_inv    = dist_y ? y_inv_q : x_inv_q;
		d_diff   = {d_pix[CW-1], d_pix} * (CW+1)'(256) - {d_c[CW-1], d_c};
		d_abs    = d_diff[CW] ? CW'(-d_diff) : CW'(d_diff);
		d_prod   = (CW+24)'(d_abs) * (CW+24)'(d_inv);
		d_scaled = {d_prod, {TB{1'b0}}};
		d_pos    = (d_scaled[CW+24+TB-1:24] > (CW+TB)'(TABLE_SIDE-1))
			? TB'(TABLE_SIDE-1) : d_scaled[24+TB-1:24];
	end

	// weight multipliers, one per colour and alpha channel; the weight sum adds the tap
	logic signed [SUM_W-1:0] acc_r_q, acc_g_q, acc_b_q, acc_a_q;
	pix_t st_rdata, st_wdata;
	logic st_we;
	logic [PB-1:0] st_raddr, st_waddr, clr_q;

	function automatic logic signed [SUM_W-1:0] wmul(
		input logic signed [15:0] w, input logic [23:0] v);
		logic signed [40:0] p;
		p = 41'(w) * $signed({17'd0, v});
		return SUM_W'(p);
	endfunction

	fssa_store #(.DEPTH(NPIX)) u_store (
		.clk(clk), .raddr(st_raddr), .rdata(st_rdata),
		.we(st_we), .waddr(st_waddr), .wdata(st_wdata)
	);

	assign tab_addr = {ty_q, tx_q};
	assign st_raddr = (state_q == ST_PRD) ? ((PB'(row_q) << XB) | PB'(col_q)) : paddr_q;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	// floor and ceil of signed Q8
	function automatic logic signed [PIXW-1:0] fl8(input logic signed [CW-1:0] v);
		return v[CW-1:8];
	endfunction
	function automatic logic signed [PIXW-1:0] ce8(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		t = v + CW'(255);
		return t[CW-1:8];
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			st_we     <= 1'b0;
			dist_y    <= 1'b0;
		end else begin
			st_we <= (state_q == ST_CLEAR) || (state_q == ST_WR);
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					st_waddr <= clr_q;
					st_wdata <= '0;
					clr_q    <= clr_q + PB'(1);
					if (clr_q == PB'(NPIX-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cx_q   <= CW'(sample_x) - CW'(128);
						cy_q   <= CW'(sample_y) - CW'(128);
						rr_q   <= radiance_red;
						rg_q   <= radiance_green;
						rb_q   <= radiance_blue;
						al_q   <= sample_alpha;
						tidx_q <= table_index;
						twt_q  <= table_weight;
						col_q  <= pixel_column;
						row_q  <= pixel_row;
						status       <= 1'b0;
						red_sum      <= '0;
						green_sum    <= '0;
						blue_sum     <= '0;
						alpha_sum    <= '0;
						weight_total <= '0;
						case (operation)
							OP_LOAD: state_q <= ST_TAB;
							OP_ADD:  state_q <= ST_SETUP;
							OP_READ: state_q <= ST_PRD;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_TAB: begin
					if (32'(tidx_q) < NTAB) wtab[TAB_W'(tidx_q)] <= twt_q;
					state_q <= ST_OUT;
				end
				ST_PRD: begin
					// store read of the requested pixel
					state_q <= ST_PRD2;
				end
				ST_PRD2: begin
					if (PIXW'(col_q) < xc_eff && PIXW'(row_q) < yc_eff) begin
						red_sum      <= st_rdata.red;
						green_sum    <= st_rdata.green;
						blue_sum     <= st_rdata.blue;
						alpha_sum    <= st_rdata.alpha;
						weight_total <= st_rdata.weight;
					end
					state_q <= ST_OUT;
				end
				ST_SETUP: begin
					x0_q <= ce8(cx_q - CW'(rx_eff));
					x1_q <= fl8(cx_q + CW'(rx_eff));
					y0_q <= ce8(cy_q - CW'(ry_eff));
					y1_q <= fl8(cy_q + CW'(ry_eff));
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					logic signed [PIXW-1:0] a0, a1, b0, b1;
					a0 = x0_q; a1 = x1_q; b0 = y0_q; b1 = y1_q;
					if (a0 < $signed(PIXW'(x_start_q))) a0 = $signed(PIXW'(x_start_q));
					if (a1 > $signed(PIXW'(x_start_q) + xc_eff - PIXW'(1)))
						a1 = $signed(PIXW'(x_start_q) + xc_eff - PIXW'(1));
					if (b0 < $signed(PIXW'(y_start_q))) b0 = $signed(PIXW'(y_start_q));
					if (b1 > $signed(PIXW'(y_start_q) + yc_eff - PIXW'(1)))
						b1 = $signed(PIXW'(y_start_q) + yc_eff - PIXW'(1));
					x0_q <= a0; x1_q <= a1; y0_q <= b0; y1_q <= b1;
					x_q  <= a0; y_q  <= b0;
					dist_y <= 1'b1;
					if ((a1 < a0) || (b1 < b0)) begin
						status  <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					ty_q    <= d_pos;
					dist_y  <= 1'b0;
					x_q     <= x0_q;
					state_q <= ST_TX;
				end
				ST_TX: begin
					logic [PIXW-1:0] rx, ry;
					rx = PIXW'(x_q - $signed(PIXW'(x_start_q)));
					ry = PIXW'(y_q - $signed(PIXW'(y_start_q)));
					tx_q    <= d_pos;
					paddr_q <= PB'({ry[YB-1:0], rx[XB-1:0]});
					state_q <= ST_RD;
				end
				ST_RD: begin
					tab_q   <= wtab[tab_addr];
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_r_q <= wmul(tab_q, rr_q);
					acc_g_q <= wmul(tab_q, rg_q);
					acc_b_q <= wmul(tab_q, rb_q);
					acc_a_q <= wmul(tab_q, 24'(al_q));
					state_q <= ST_WR;
				end
				ST_WR: begin
					st_waddr <= paddr_q;
					st_wdata.red    <= sat_add(st_rdata.red, acc_r_q);
					st_wdata.green  <= sat_add(st_rdata.green, acc_g_q);
					st_wdata.blue   <= sat_add(st_rdata.blue, acc_b_q);
					st_wdata.alpha  <= sat_add(st_rdata.alpha, acc_a_q);
					st_wdata.weight <= sat_add(st_rdata.weight, SUM_W'(tab_q));
					if (x_q < x1_q) begin
						x_q     <= x_q + PIXW'(1);
						state_q <= ST_TX;
					end else if (y_q < y1_q) begin
						y_q     <= y_q + PIXW'(1);
						dist_y  <= 1'b1;
						state_q <= ST_ROW;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// wait for the write-back to land before next beat
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/fssa_store.sv
// ---------------------------------------------------------------------------
// fssa_store
// Pixel accumulation memory: one read port, one write port, data registered.
// ---------------------------------------------------------------------------
module fssa_store import fssa_pkg::*; #(
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output pix_t                     rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  pix_t                     wdata
);

	pix_t mem [DEPTH];

	// registered read, single write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule
